// ===== rtl/bbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;
   localparam int SUM_W       = 12;

   typedef logic [23:0] pixel_type;
   typedef pixel_type [2:0] column_type;
   typedef logic [8:0][7:0] tap_type;

   typedef struct packed {
      logic       sum_en;
      logic       mul_en;
      logic [8:0] mask;
      logic [3:0] count;
   } lane_ctrl_type;

   // 2^16 / count, rounded up; exact for every sum a 3x3 window can reach
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bbr_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbr_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [47:0]   rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [47:0]   wr_data
);

   logic [47:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bbr_mean_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbr_mean_lane (
   input  wire logic                   clock,
   input  wire bbr_pkg::lane_ctrl_type ctrl,
   input  wire bbr_pkg::tap_type       taps,
   output logic [7:0]                  mean
);

   logic [bbr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [7:0] mean_ff;
   logic [bbr_pkg::SUM_W+bbr_pkg::RECIP_W-1:0] product;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 9; i++) begin
         sum_in = sum_in + (ctrl.mask[i] ? bbr_pkg::SUM_W'(taps[i]) : '0);
      end
   end

   assign product = (bbr_pkg::SUM_W+bbr_pkg::RECIP_W)'(sum_ff) *
                    (bbr_pkg::SUM_W+bbr_pkg::RECIP_W)'(bbr_pkg::recip(ctrl.count));

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_ff <= sum_in;
      end
      if (ctrl.mul_en) begin
         mean_ff <= product[bbr_pkg::RECIP_SHIFT +: 8];
      end
   end

   assign mean = mean_ff;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3 box blur over an RGB pixel stream in raster order. Each output pixel is,
// per channel, the truncated mean of the in-frame pixels of its 3x3
// neighborhood, computed from the original pixels. Results lag the input by
// one row plus one pixel; after the last pixel of a frame, image_width+1
// flush items (cmd=1) drain the tail, and frame_end marks the last result.
// A flush item before the frame's last pixel is accepted and ignored.
// Timing: one item at a time. An item that yields a result passes in order
// through the line store read; line store write, window update and the three
// channel lane sums; reciprocal multiply; output register load, which waits
// while a result is still held and not taken. An item without a result ends
// after the line store write and window update; an ignored flush is only
// accepted. The output register lets the next item in while a result waits.
// Write image_width/image_height only while idle; a write restarts the frame.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_cmd,
   input  wire logic [7:0]                       req_red_in,
   input  wire logic [7:0]                       req_green_in,
   input  wire logic [7:0]                       req_blue_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_red_out,
   output logic [7:0]                            rsp_green_out,
   output logic [7:0]                            rsp_blue_out,
   output logic                                  rsp_frame_end,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bbr_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int WEW = (CW > bbr_pkg::CSR_DATA_W) ? CW : bbr_pkg::CSR_DATA_W;
   localparam int HEW = (RW > bbr_pkg::CSR_DATA_W) ? RW : bbr_pkg::CSR_DATA_W;
   localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_UPD  = 4'b0010,
      S_MUL  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] w_ff, w_clamp;
   logic [RW-1:0] h_ff, h_clamp;
   logic [WEW-1:0] w_ext;
   logic [HEW-1:0] h_ext;

   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [RW-1:0] in_row_ff, out_row_ff;

   bbr_pkg::pixel_type  pix_ff;
   bbr_pkg::column_type win_left_ff, win_mid_ff, right;
   logic [3:0] count_ff, count_in;
   logic       frame_end_ff;

   logic        accept, tail, start, csr_write;
   logic        has_out, last;
   logic        col_ok0, col_ok2, row_ok0, row_ok2;
   logic [1:0]  col_cnt, row_cnt;
   logic [8:0]  mask;
   logic [CW:0] in_col_inc, out_col_inc;
   logic [RW:0] out_row_inc;
   logic [47:0] ls_rd, ls_wr;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic        rsp_frame_end_ff;
   logic        load_out;
   logic [2:0][7:0] lane_mean;

   bbr_pkg::lane_ctrl_type lane_ctrl;
   bbr_pkg::tap_type       lane_taps [3];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid &&
                      (csr_index == bbr_pkg::REG_IMAGE_WIDTH ||
                       csr_index == bbr_pkg::REG_IMAGE_HEIGHT);

   assign w_ext = WEW'(csr_data);
   assign h_ext = HEW'(csr_data);
   assign w_clamp = (w_ext == '0) ? CW'(1) :
                    (w_ext > WEW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext[CW-1:0];
   assign h_clamp = (h_ext == '0) ? RW'(1) :
                    (h_ext > HEW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : h_ext[RW-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign tail      = in_row_ff >= h_ff;
   assign start     = accept && (req_cmd == bbr_pkg::CMD_PIXEL || tail);

   assign right[0] = ls_rd[47:24];
   assign right[1] = ls_rd[23:0];
   assign right[2] = pix_ff;
   assign ls_wr    = {ls_rd[23:0], pix_ff};

   assign has_out = (in_row_ff >= RW'(2)) || (in_row_ff == RW'(1) && in_col_ff != '0);

   assign in_col_inc  = {1'b0, in_col_ff} + (CW+1)'(1);
   assign out_col_inc = {1'b0, out_col_ff} + (CW+1)'(1);
   assign out_row_inc = {1'b0, out_row_ff} + (RW+1)'(1);

   assign col_ok0 = out_col_ff != '0;
   assign col_ok2 = out_col_inc < {1'b0, w_ff};
   assign row_ok0 = out_row_ff != '0;
   assign row_ok2 = out_row_inc < {1'b0, h_ff};
   assign last    = (out_row_inc >= {1'b0, h_ff}) && (out_col_inc >= {1'b0, w_ff});

   assign col_cnt  = 2'd1 + {1'b0, col_ok0} + {1'b0, col_ok2};
   assign row_cnt  = 2'd1 + {1'b0, row_ok0} + {1'b0, row_ok2};
   assign count_in = {2'b00, col_cnt} * {2'b00, row_cnt};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            mask[c*3+r] = (c == 0 ? col_ok0 : (c == 2 ? col_ok2 : 1'b1)) &&
                          (r == 0 ? row_ok0 : (r == 2 ? row_ok2 : 1'b1));
         end
      end
   end

   bbr_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (start),
      .rd_addr (in_col_ff[AW-1:0]),
      .rd_data (ls_rd),
      .wr_en   (state_ff == S_UPD),
      .wr_addr (in_col_ff[AW-1:0]),
      .wr_data (ls_wr)
   );

   assign lane_ctrl.sum_en = (state_ff == S_UPD);
   assign lane_ctrl.mul_en = (state_ff == S_MUL);
   assign lane_ctrl.mask   = mask;
   assign lane_ctrl.count  = count_ff;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      localparam int SH = 16 - 8 * k;
      always_comb begin
         for (int r = 0; r < 3; r++) begin
            lane_taps[k][r]   = win_left_ff[r][SH +: 8];
            lane_taps[k][3+r] = win_mid_ff[r][SH +: 8];
            lane_taps[k][6+r] = right[r][SH +: 8];
         end
      end
      bbr_mean_lane u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .taps  (lane_taps[k]),
         .mean  (lane_mean[k])
      );
   end

   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_UPD;
         S_UPD:  state_in = has_out ? S_MUL : S_IDLE;
         S_MUL:  state_in = S_OUT;
         S_OUT:  if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         w_ff       <= CW'(RST_W);
         h_ff       <= RW'(RST_H);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               bbr_pkg::REG_IMAGE_WIDTH:  w_ff <= w_clamp;
               bbr_pkg::REG_IMAGE_HEIGHT: h_ff <= h_clamp;
               default: ;
            endcase
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (state_ff == S_UPD) begin
            if (has_out && last) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else begin
               if (in_col_inc >= {1'b0, w_ff}) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + RW'(1);
               end else begin
                  in_col_ff <= in_col_inc[CW-1:0];
               end
               if (has_out) begin
                  if (out_col_inc >= {1'b0, w_ff}) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_inc[RW-1:0];
                  end else begin
                     out_col_ff <= out_col_inc[CW-1:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pix_ff <= tail ? '0 : {req_red_in, req_green_in, req_blue_in};
      end
      if (state_ff == S_UPD) begin
         win_left_ff  <= win_mid_ff;
         win_mid_ff   <= right;
         count_ff     <= count_in;
         frame_end_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_red_ff       <= lane_mean[0];
         rsp_green_ff     <= lane_mean[1];
         rsp_blue_ff      <= lane_mean[2];
         rsp_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

`default_nettype wire

// ===== rtl/bbr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red_out,
   input wire logic [7:0] rsp_green_out,
   input wire logic [7:0] rsp_blue_out,
   input wire logic       rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red_out) && $stable(rsp_green_out) &&
         $stable(rsp_blue_out) && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == bbr_pkg::CMD_PIXEL |=> !req_ready)
      else $error("pixel item accepted without busy cycle");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("result without matching item");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire
